/* rtl/idps_pkg.sv */
// Shared types, codes and constants of the input deck presence sequencer.
package idps_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int ID_W      = 4;
    localparam int MODE_W    = 8;
    localparam int DELAY_W   = 4;
    localparam int WALK_W    = 4;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        OP_SAMPLE     = 2'd0,
        OP_POWER_UP   = 2'd1,
        OP_POWER_DOWN = 2'd2,
        OP_SET_MODE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        DS_OFF       = 3'd0,
        DS_DISC      = 3'd1,
        DS_TURNING   = 3'd2,
        DS_ON        = 3'd3,
        DS_FORCE_OFF = 3'd4,
        DS_FORCE_ON  = 3'd5
    } deck_status_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_EXEC,
        CS_WALK,
        CS_STEP,
        CS_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic walk_adv;
        logic sweep;
        logic load_out;
    } idps_cmd_t;

    typedef struct packed {
        logic sweep_due;
        logic walk_done;
        logic out_free;
    } idps_status_t;

    // Module ids
    localparam logic [ID_W-1:0] ID_SHORT    = 4'd0;
    localparam logic [ID_W-1:0] ID_FULL     = 4'd1;
    localparam logic [ID_W-1:0] ID_A        = 4'd2;
    localparam logic [ID_W-1:0] ID_B        = 4'd3;
    localparam logic [ID_W-1:0] ID_C        = 4'd4;
    localparam logic [ID_W-1:0] ID_KB_A     = 4'd5;
    localparam logic [ID_W-1:0] ID_KB_B     = 4'd6;
    localparam logic [ID_W-1:0] ID_DISC     = 4'd7;
    localparam logic [ID_W-1:0] ID_TOUCHPAD = 4'd8;

    // Slot roles
    localparam logic [SLOT_W-1:0] SLOT_TOUCHPAD = 3'd5;
    localparam logic [SLOT_W-1:0] SLOT_NC       = 3'd6;
    localparam logic [SLOT_W-1:0] SLOT_HUB      = 3'd7;
    localparam logic [SLOT_W-1:0] SLOT_LAST     = 3'(NUM_SLOTS - 1);
    localparam logic [WALK_W-1:0] TOP_ROW_LAST  = 4'd4;

    // Detect modes
    localparam logic [MODE_W-1:0] MODE_NONE      = 8'h00;
    localparam logic [MODE_W-1:0] MODE_AUTO      = 8'h01;
    localparam logic [MODE_W-1:0] MODE_FORCE_ON  = 8'h02;
    localparam logic [MODE_W-1:0] MODE_FORCE_OFF = 8'h04;

    localparam logic [DELAY_W-1:0] DELAY_MAX           = 4'd15;
    localparam logic [DELAY_W-1:0] TURN_ON_POLLS_RESET = 4'd3;

    // Register index of turn_on_polls (byte address 4*index)
    localparam logic REG_TURN_ON_POLLS = 1'b0;

    // Number of top-row slots a module covers; zero marks an id that fails the check.
    function automatic logic [WALK_W-1:0] module_span(input logic [ID_W-1:0] id);
        logic [WALK_W-1:0] span;
        begin
            unique case (id)
                ID_FULL:          span = 4'd5;
                ID_A, ID_KB_A:    span = 4'd3;
                ID_B, ID_KB_B:    span = 4'd2;
                ID_C:             span = 4'd1;
                default:          span = 4'd0;
            endcase
            return span;
        end
    endfunction

endpackage

/* rtl/idps_ctrl.sv */
// Sequencing controller of the input deck presence sequencer.
module idps_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  idps_pkg::idps_status_t status,
    output idps_pkg::idps_cmd_t    cmd
);
    import idps_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC:
            begin
                state_next = status.sweep_due ? CS_WALK : CS_DONE;
            end
            CS_WALK:
            begin
                if (status.walk_done)
                begin
                    state_next = CS_STEP;
                end
            end
            CS_STEP:
            begin
                state_next = CS_DONE;
            end
            CS_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            CS_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            CS_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            CS_WALK:
            begin
                cmd.walk_adv = !status.walk_done;
            end
            CS_STEP:
            begin
                cmd.sweep = 1'b1;
            end
            CS_DONE:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/idps_dp.sv */
// Datapath of the input deck presence sequencer: slot store, deck state, walk and result register.
module idps_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  idps_pkg::idps_cmd_t           cmd,
    output idps_pkg::idps_status_t        status,
    input  logic [1:0]                    opcode,
    input  logic [idps_pkg::ID_W-1:0]     module_id,
    input  logic [idps_pkg::MODE_W-1:0]   mode,
    input  logic [idps_pkg::DELAY_W-1:0]  turn_on_polls,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    deck_status,
    output logic                          power_enable,
    output logic                          touchpad_emulation,
    output logic [idps_pkg::SLOT_W-1:0]   mux_select,
    output logic [idps_pkg::ID_W-1:0]     out_slots [idps_pkg::NUM_SLOTS]
);
    import idps_pkg::*;

    // Captured beat
    op_t               op_reg;
    logic [ID_W-1:0]   id_reg;
    logic [MODE_W-1:0] mode_reg;

    // Architectural state
    logic [ID_W-1:0]    slot_reg [NUM_SLOTS];
    logic [ID_W-1:0]    slot_next [NUM_SLOTS];
    deck_status_t       state_reg, state_next;
    logic [SLOT_W-1:0]  chan_reg, chan_next;
    logic [SLOT_W-1:0]  mux_reg, mux_next;
    logic [DELAY_W-1:0] delay_reg, delay_next;
    logic               emu_reg, emu_next;
    logic               power_reg, power_next;
    logic               polling_reg, polling_next;
    logic [MODE_W-1:0]  smode_reg, smode_next;

    // Populated walk
    logic [WALK_W-1:0] walk_idx_reg, walk_idx_next;
    logic              walk_ok_reg, walk_ok_next;

    // Result register
    logic               out_valid_reg, out_valid_next;
    logic [2:0]         out_state_reg;
    logic               out_power_reg;
    logic               out_emu_reg;
    logic [SLOT_W-1:0]  out_mux_reg;
    logic [ID_W-1:0]    out_slot_reg [NUM_SLOTS];

    logic [ID_W-1:0]    walk_id;
    logic [WALK_W-1:0]  walk_span;
    logic               hub_bad;
    logic               populated;
    logic [DELAY_W-1:0] delay_inc;

    assign walk_id   = slot_reg[walk_idx_reg[SLOT_W-1:0]];
    assign walk_span = module_span(walk_id);
    assign hub_bad   = (slot_reg[SLOT_HUB] == ID_SHORT) || (slot_reg[SLOT_HUB] == ID_DISC);
    assign populated = walk_ok_reg && (slot_reg[SLOT_TOUCHPAD] == ID_TOUCHPAD);
    assign delay_inc = (delay_reg < DELAY_MAX) ? delay_reg + 4'd1 : delay_reg;

    assign status.sweep_due = (op_reg == OP_SAMPLE) && polling_reg && (chan_reg == SLOT_LAST);
    assign status.walk_done = (walk_idx_reg > TOP_ROW_LAST) || !walk_ok_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op_t'(opcode);
            id_reg   <= module_id;
            mode_reg <= mode;
        end
    end

    always_comb
    begin
        slot_next     = slot_reg;
        state_next    = state_reg;
        chan_next     = chan_reg;
        mux_next      = mux_reg;
        delay_next    = delay_reg;
        emu_next      = emu_reg;
        power_next    = power_reg;
        polling_next  = polling_reg;
        smode_next    = smode_reg;
        walk_idx_next = walk_idx_reg;
        walk_ok_next  = walk_ok_reg;

        if (cmd.exec)
        begin
            walk_idx_next = '0;
            walk_ok_next  = 1'b1;
            unique case (op_reg)
                OP_SAMPLE:
                begin
                    if (polling_reg)
                    begin
                        slot_next[chan_reg] = id_reg;
                        chan_next           = chan_reg + 3'd1;
                        mux_next            = chan_reg + 3'd1;
                    end
                end
                OP_POWER_UP:
                begin
                    if (state_reg == DS_FORCE_ON)
                    begin
                        power_next = 1'b1;
                    end
                    else if (state_reg != DS_FORCE_OFF)
                    begin
                        state_next = DS_DISC;
                    end
                    polling_next = 1'b1;
                end
                OP_POWER_DOWN:
                begin
                    if (state_reg == DS_FORCE_ON)
                    begin
                        power_next = 1'b0;
                    end
                    else if (state_reg != DS_FORCE_OFF)
                    begin
                        state_next = DS_OFF;
                        power_next = 1'b0;
                        mux_next   = SLOT_NC;
                    end
                    polling_next = 1'b0;
                end
                OP_SET_MODE:
                begin
                    if ((mode_reg != smode_reg) && (mode_reg != MODE_NONE))
                    begin
                        priority if (mode_reg == MODE_AUTO)
                        begin
                            state_next = DS_DISC;
                            power_next = 1'b0;
                        end
                        else if (mode_reg == MODE_FORCE_ON)
                        begin
                            state_next = DS_FORCE_ON;
                            power_next = 1'b1;
                        end
                        else if (mode_reg == MODE_FORCE_OFF)
                        begin
                            state_next = DS_FORCE_OFF;
                            power_next = 1'b0;
                        end
                        else
                        begin
                            state_next = state_reg;
                        end
                        smode_next = mode_reg;
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end

        // Advance by the module span; drop out on a bad hub or an unknown id
        if (cmd.walk_adv)
        begin
            if (hub_bad || (walk_span == '0))
            begin
                walk_ok_next = 1'b0;
            end
            else
            begin
                walk_idx_next = walk_idx_reg + walk_span;
            end
        end

        if (cmd.sweep)
        begin
            priority case (state_reg)
                DS_DISC:
                begin
                    if (populated)
                    begin
                        delay_next = '0;
                        state_next = DS_TURNING;
                    end
                    else
                    begin
                        emu_next = 1'b1;
                    end
                end
                DS_TURNING:
                begin
                    delay_next = delay_inc;
                    if (populated && (delay_inc > turn_on_polls))
                    begin
                        emu_next   = 1'b0;
                        power_next = 1'b1;
                        state_next = DS_ON;
                    end
                    else if (slot_reg[SLOT_TOUCHPAD] != ID_TOUCHPAD)
                    begin
                        emu_next   = 1'b1;
                        state_next = DS_DISC;
                    end
                end
                DS_ON:
                begin
                    if (!populated)
                    begin
                        power_next = 1'b0;
                        emu_next   = 1'b1;
                        state_next = DS_DISC;
                    end
                end
                DS_FORCE_ON:
                begin
                    emu_next = 1'b0;
                end
                DS_FORCE_OFF:
                begin
                    emu_next = 1'b1;
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_reg[i] <= ID_DISC;
            end
            state_reg    <= DS_OFF;
            chan_reg     <= '0;
            mux_reg      <= '0;
            delay_reg    <= '0;
            emu_reg      <= 1'b1;
            power_reg    <= 1'b0;
            polling_reg  <= 1'b0;
            smode_reg    <= MODE_NONE;
            walk_idx_reg <= '0;
            walk_ok_reg  <= 1'b0;
        end
        else
        begin
            slot_reg     <= slot_next;
            state_reg    <= state_next;
            chan_reg     <= chan_next;
            mux_reg      <= mux_next;
            delay_reg    <= delay_next;
            emu_reg      <= emu_next;
            power_reg    <= power_next;
            polling_reg  <= polling_next;
            smode_reg    <= smode_next;
            walk_idx_reg <= walk_idx_next;
            walk_ok_reg  <= walk_ok_next;
        end
    end

    // Hold the result beat until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_state_reg <= state_reg;
            out_power_reg <= power_reg;
            out_emu_reg   <= emu_reg;
            out_mux_reg   <= mux_reg;
            out_slot_reg  <= slot_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign deck_status        = out_state_reg;
    assign power_enable       = out_power_reg;
    assign touchpad_emulation = out_emu_reg;
    assign mux_select         = out_mux_reg;
    assign out_slots          = out_slot_reg;

endmodule

/* rtl/input_deck_presence_sequencer.sv */
// Sequencing: the input beat is captured in idle and executed, and for an item that ends no sweep
// the result is then loaded; a sample that closes a sweep first adds the populated walk (one
// top-row module per cycle, then a step to leave it) and one deck step before the load.
// Flow: one item in work at a time; the next beat is taken once the result sits in the output
// register, and an unread result there stalls the following item at its load. Reset (rst_n low,
// asynchronous): all slots read disconnected, deck off, polling stopped, emulation on,
// turn_on_polls = 3.
module input_deck_presence_sequencer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [idps_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [idps_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [idps_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         opcode,
    input  logic [3:0]                         module_id,
    input  logic [7:0]                         mode,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [2:0]                         deck_status,
    output logic                               power_enable,
    output logic                               touchpad_emulation,
    output logic [2:0]                         mux_select,
    output logic [3:0]                         slot_id_0,
    output logic [3:0]                         slot_id_1,
    output logic [3:0]                         slot_id_2,
    output logic [3:0]                         slot_id_3,
    output logic [3:0]                         slot_id_4,
    output logic [3:0]                         slot_id_5,
    output logic [3:0]                         slot_id_6,
    output logic [3:0]                         slot_id_7
);
    import idps_pkg::*;

    logic [DELAY_W-1:0] turn_on_polls_reg, turn_on_polls_next;
    logic               reg_sel;
    logic               cfg_write;
    idps_cmd_t          cmd;
    idps_status_t       status;
    logic [ID_W-1:0]    slots [NUM_SLOTS];

    assign pready    = 1'b1;
    assign reg_sel   = (paddr[APB_ADDR_W-1] == REG_TURN_ON_POLLS);
    assign cfg_write = psel && penable && pwrite && pready && reg_sel;
    assign prdata    = reg_sel ? APB_DATA_W'(turn_on_polls_reg) : '0;

    always_comb
    begin
        turn_on_polls_next = turn_on_polls_reg;
        if (cfg_write)
        begin
            turn_on_polls_next = pwdata[DELAY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_on_polls_reg <= TURN_ON_POLLS_RESET;
        end
        else
        begin
            turn_on_polls_reg <= turn_on_polls_next;
        end
    end

    idps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    idps_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .opcode             (opcode),
        .module_id          (module_id),
        .mode               (mode),
        .turn_on_polls      (turn_on_polls_reg),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .deck_status        (deck_status),
        .power_enable       (power_enable),
        .touchpad_emulation (touchpad_emulation),
        .mux_select         (mux_select),
        .out_slots          (slots)
    );

    assign slot_id_0 = slots[0];
    assign slot_id_1 = slots[1];
    assign slot_id_2 = slots[2];
    assign slot_id_3 = slots[3];
    assign slot_id_4 = slots[4];
    assign slot_id_5 = slots[5];
    assign slot_id_6 = slots[6];
    assign slot_id_7 = slots[7];

    // A taken beat keeps the input side closed for the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while previous item in work");

    // A result appears only after an item went in
    a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result without a preceding item");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> turn_on_polls_reg == $past(pwdata[DELAY_W-1:0]))
        else $error("turn_on_polls write lost");

endmodule

/* dv/tb_input_deck_presence_sequencer.sv */
// Self-checking testbench for the input deck presence sequencer: directed and random beats.
module tb_input_deck_presence_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import idps_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 35;
    localparam int NUM_PHASES  = 6;

    typedef struct packed {
        op_t        op;
        logic [3:0] id;
        logic [7:0] mode;
    } deck_item_t;

    typedef struct packed {
        logic [2:0]      state;
        logic            power;
        logic            emul;
        logic [2:0]      mux;
        logic [7:0][3:0] slots;
    } deck_resp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic        pready;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  opcode = 2'd0;
    logic [3:0]  module_id = 4'd0;
    logic [7:0]  mode = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  deck_status;
    logic        power_enable;
    logic        touchpad_emulation;
    logic [2:0]  mux_select;
    logic [3:0]  slot_id_0, slot_id_1, slot_id_2, slot_id_3;
    logic [3:0]  slot_id_4, slot_id_5, slot_id_6, slot_id_7;

    input_deck_presence_sequencer DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .opcode             (opcode),
        .module_id          (module_id),
        .mode               (mode),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .deck_status        (deck_status),
        .power_enable       (power_enable),
        .touchpad_emulation (touchpad_emulation),
        .mux_select         (mux_select),
        .slot_id_0          (slot_id_0),
        .slot_id_1          (slot_id_1),
        .slot_id_2          (slot_id_2),
        .slot_id_3          (slot_id_3),
        .slot_id_4          (slot_id_4),
        .slot_id_5          (slot_id_5),
        .slot_id_6          (slot_id_6),
        .slot_id_7          (slot_id_7)
    );

    always #4 clk = ~clk;

    // Predictor state, reset values
    logic [3:0]   m_slot [NUM_SLOTS] = '{default: ID_DISC};
    deck_status_t m_state = DS_OFF;
    logic [2:0]  m_chan = 3'd0;
    logic [2:0]  m_mux = 3'd0;
    logic [3:0]  m_delay = 4'd0;
    logic        m_emul = 1'b1;
    logic        m_power = 1'b0;
    logic        m_polling = 1'b0;
    logic [7:0]  m_mode = MODE_NONE;
    logic [3:0]  m_top = TURN_ON_POLLS_RESET;

    deck_item_t deck_item_q [$];
    deck_resp_t deck_response_q [$];
    deck_item_t drv_item;

    bit          beat_taken = 1'b0;
    int          fail_count = 0;
    int          cycle_count = 0;
    int unsigned send_idle_pct = 35;
    int unsigned recv_idle_pct = 50;

    // Stimulus-side tracking of the poll channel
    logic [2:0]  gen_chan = 3'd0;
    bit          gen_polling = 1'b0;
    int          phase_items = 0;

    function automatic bit deck_complete();
        int unsigned pos;
        logic [3:0] hub;
        hub = m_slot[SLOT_HUB];
        if (hub == ID_SHORT || hub == ID_DISC)
            return 1'b0;
        pos = 0;
        while (pos <= 4) begin
            case (m_slot[pos])
                ID_FULL:       pos += 5;
                ID_A, ID_KB_A: pos += 3;
                ID_B, ID_KB_B: pos += 2;
                ID_C:          pos += 1;
                default:       return 1'b0;
            endcase
        end
        return m_slot[SLOT_TOUCHPAD] == ID_TOUCHPAD;
    endfunction

    function automatic deck_resp_t predict_deck_response(deck_item_t it);
        deck_resp_t r;
        case (it.op)
            OP_SAMPLE: begin
                if (m_polling) begin
                    m_slot[m_chan] = it.id;
                    m_chan = m_chan + 3'd1;
                    m_mux = m_chan;
                    // step the deck machine once per full sweep
                    if (m_chan == 3'd0) begin
                        case (m_state)
                            DS_DISC: begin
                                if (deck_complete()) begin
                                    m_delay = 4'd0;
                                    m_state = DS_TURNING;
                                end else begin
                                    m_emul = 1'b1;
                                end
                            end
                            DS_TURNING: begin
                                if (m_delay < DELAY_MAX)
                                    m_delay = m_delay + 4'd1;
                                if (deck_complete() && m_delay > m_top) begin
                                    m_emul = 1'b0;
                                    m_power = 1'b1;
                                    m_state = DS_ON;
                                end else if (m_slot[SLOT_TOUCHPAD] != ID_TOUCHPAD) begin
                                    m_emul = 1'b1;
                                    m_state = DS_DISC;
                                end
                            end
                            DS_ON: begin
                                if (!deck_complete()) begin
                                    m_power = 1'b0;
                                    m_emul = 1'b1;
                                    m_state = DS_DISC;
                                end
                            end
                            DS_FORCE_ON:  m_emul = 1'b0;
                            DS_FORCE_OFF: m_emul = 1'b1;
                            default: ;
                        endcase
                    end
                end
            end
            OP_POWER_UP: begin
                if (m_state == DS_FORCE_ON)
                    m_power = 1'b1;
                else if (m_state != DS_FORCE_OFF)
                    m_state = DS_DISC;
                m_polling = 1'b1;
            end
            OP_POWER_DOWN: begin
                if (m_state == DS_FORCE_ON) begin
                    m_power = 1'b0;
                end else if (m_state != DS_FORCE_OFF) begin
                    m_state = DS_OFF;
                    m_power = 1'b0;
                    m_mux = SLOT_NC;
                end
                m_polling = 1'b0;
            end
            default: begin
                if (it.mode != m_mode && it.mode != MODE_NONE) begin
                    if (it.mode == MODE_AUTO) begin
                        m_state = DS_DISC;
                        m_power = 1'b0;
                    end else if (it.mode == MODE_FORCE_ON) begin
                        m_state = DS_FORCE_ON;
                        m_power = 1'b1;
                    end else if (it.mode == MODE_FORCE_OFF) begin
                        m_state = DS_FORCE_OFF;
                        m_power = 1'b0;
                    end
                    m_mode = it.mode;
                end
            end
        endcase
        r.state = m_state;
        r.power = m_power;
        r.emul  = m_emul;
        r.mux   = m_mux;
        for (int j = 0; j < NUM_SLOTS; j++)
            r.slots[j] = m_slot[j];
        return r;
    endfunction

    function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void push_item(op_t op, logic [3:0] id, logic [7:0] md);
        deck_item_t it;
        it.op = op;
        it.id = id;
        it.mode = md;
        deck_item_q.push_back(it);
        if (op != OP_SAMPLE || gen_polling)
            phase_items++;
        if (op == OP_SAMPLE && gen_polling)
            gen_chan = gen_chan + 3'd1;
        else if (op == OP_POWER_UP)
            gen_polling = 1'b1;
        else if (op == OP_POWER_DOWN)
            gen_polling = 1'b0;
    endfunction

    function automatic logic [7:0] pick_mode();
        case ($urandom_range(5))
            0:       return MODE_NONE;
            1:       return MODE_AUTO;
            2:       return MODE_FORCE_ON;
            3:       return MODE_FORCE_OFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Power up if needed, then sweep a plausible deck layout, maybe breaking one sweep.
    task automatic queue_deck_session();
        logic [3:0]  layout [NUM_SLOTS];
        logic [3:0]  sweep_ids [NUM_SLOTS];
        int unsigned pos;
        int unsigned sweeps;
        int unsigned bad_sweep;
        for (int j = 0; j < NUM_SLOTS; j++)
            layout[j] = 4'($urandom_range(15));
        pos = 0;
        while (pos <= 4) begin
            layout[pos] = 4'($urandom_range(6, 1));
            case (layout[pos])
                ID_FULL:       pos += 5;
                ID_A, ID_KB_A: pos += 3;
                ID_B, ID_KB_B: pos += 2;
                default:       pos += 1;
            endcase
        end
        layout[SLOT_TOUCHPAD] = ID_TOUCHPAD;
        layout[SLOT_HUB] = 4'($urandom_range(14, 1));
        if (layout[SLOT_HUB] == ID_DISC)
            layout[SLOT_HUB] = 4'd15;

        if (m_state == DS_FORCE_ON || m_state == DS_FORCE_OFF || $urandom_range(9) == 0)
            push_item(OP_SET_MODE, 4'($urandom_range(15)), MODE_AUTO);
        if (!gen_polling || $urandom_range(4) == 0)
            push_item(OP_POWER_UP, 4'($urandom_range(15)), 8'($urandom_range(255)));
        // align to channel 0 so each sweep sees a whole layout
        while (gen_chan != 3'd0)
            push_item(OP_SAMPLE, layout[gen_chan], 8'($urandom_range(255)));

        sweeps = $urandom_range((m_top < 14) ? int'(m_top) + 4 : 18, 2);
        bad_sweep = ($urandom_range(9) < 3) ? $urandom_range(sweeps - 1) : sweeps;
        for (int unsigned s = 0; s < sweeps; s++) begin
            for (int j = 0; j < NUM_SLOTS; j++)
                sweep_ids[j] = layout[j];
            if (s == bad_sweep) begin
                case ($urandom_range(2))
                    0:       sweep_ids[SLOT_TOUCHPAD] = 4'($urandom_range(7));
                    1:       sweep_ids[SLOT_HUB] = $urandom_range(1) ? ID_SHORT : ID_DISC;
                    default: sweep_ids[$urandom_range(4)] = $urandom_range(1) ?
                                 4'($urandom_range(15, 9)) : ID_SHORT;
                endcase
            end
            for (int j = 0; j < NUM_SLOTS; j++)
                push_item(OP_SAMPLE, sweep_ids[j], 8'($urandom_range(255)));
        end
        if ($urandom_range(9) < 4)
            push_item(OP_POWER_DOWN, 4'($urandom_range(15)), 8'($urandom_range(255)));
        if ($urandom_range(9) < 2)
            push_item(OP_SET_MODE, 4'($urandom_range(15)), pick_mode());
    endtask

    // Input driver: present the next beat or idle
    always @(negedge clk) begin
        if (rst_n && (!in_valid || beat_taken)) begin
            if (deck_item_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                drv_item = deck_item_q.pop_front();
                in_valid  <= 1'b1;
                opcode    <= drv_item.op;
                module_id <= drv_item.id;
                mode      <= drv_item.mode;
            end else begin
                in_valid <= 1'b0;
            end
        end
        beat_taken = 1'b0;
    end

    always @(negedge clk) begin
        out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            deck_response_q.push_back(predict_deck_response(drv_item));
            beat_taken = 1'b1;
        end
    end

    always @(posedge clk) begin : result_check
        deck_resp_t want;
        deck_resp_t got;
        if (rst_n && out_valid && out_ready) begin
            if (deck_response_q.size() == 0) begin
                $error("result beat with no expectation waiting");
                fail_count++;
            end else begin
                want = deck_response_q.pop_front();
                got.state = deck_status;
                got.power = power_enable;
                got.emul  = touchpad_emulation;
                got.mux   = mux_select;
                got.slots = {slot_id_7, slot_id_6, slot_id_5, slot_id_4,
                             slot_id_3, slot_id_2, slot_id_1, slot_id_0};
                compare_field("deck_status", 8'(want.state), 8'(got.state));
                compare_field("power_enable", 8'(want.power), 8'(got.power));
                compare_field("touchpad_emulation", 8'(want.emul), 8'(got.emul));
                compare_field("mux_select", 8'(want.mux), 8'(got.mux));
                for (int j = 0; j < NUM_SLOTS; j++)
                    compare_field($sformatf("slot_id_%0d", j), 8'(want.slots[j]),
                                  8'(got.slots[j]));
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [3:0]  top_val;
        int unsigned burst;
        int unsigned r;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: ignored samples, mode codes, forced states, parking, id extremes
        send_idle_pct = 35;
        recv_idle_pct = 50;
        push_item(OP_SAMPLE, 4'd15, 8'hFF);
        push_item(OP_SET_MODE, 4'd0, MODE_NONE);
        push_item(OP_SET_MODE, 4'd0, MODE_FORCE_ON);
        push_item(OP_POWER_UP, 4'd0, 8'd0);
        push_item(OP_SAMPLE, 4'd0, 8'd0);
        push_item(OP_POWER_DOWN, 4'd15, 8'hFF);
        push_item(OP_SET_MODE, 4'd0, MODE_FORCE_OFF);
        push_item(OP_POWER_UP, 4'd0, 8'd0);
        push_item(OP_POWER_DOWN, 4'd0, 8'd0);
        push_item(OP_SET_MODE, 4'd0, MODE_FORCE_OFF);
        push_item(OP_SET_MODE, 4'd15, 8'hFF);
        push_item(OP_SET_MODE, 4'd0, MODE_AUTO);
        push_item(OP_SET_MODE, 4'd0, MODE_AUTO);
        push_item(OP_POWER_UP, 4'd0, 8'd0);
        for (int j = 0; j < NUM_SLOTS; j++)
            push_item(OP_SAMPLE, (j % 2) ? 4'd0 : 4'd15, (j % 2) ? 8'h00 : 8'hFF);
        push_item(OP_POWER_DOWN, 4'd0, 8'd0);
        push_item(OP_SAMPLE, 4'd8, 8'h55);
        push_item(OP_SET_MODE, 4'd0, 8'h80);
        queue_deck_session();
        while (deck_item_q.size() > 0 || in_valid || deck_response_q.size() > 0)
            @(negedge clk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct = (p < 2) ? 35 : (p < 4) ? 50 : 0;
            recv_idle_pct = (p < 2) ? 50 : (p < 4) ? 35 : 0;
            if (p > 0) begin
                case (p)
                    1:       top_val = 4'd0;
                    2:       top_val = 4'd14;
                    3:       top_val = DELAY_MAX;
                    default: top_val = 4'($urandom_range(14));
                endcase
                // block is drained here; write the register
                @(negedge clk);
                psel    <= 1'b1;
                penable <= 1'b0;
                pwrite  <= 1'b1;
                paddr   <= APB_ADDR_W'(4 * int'(REG_TURN_ON_POLLS));
                pwdata  <= (p == 4) ? (32'($urandom()) & ~32'hF) | 32'(top_val) : 32'(top_val);
                @(negedge clk);
                penable <= 1'b1;
                do
                    @(posedge clk);
                while (!pready);
                @(negedge clk);
                psel    <= 1'b0;
                penable <= 1'b0;
                pwrite  <= 1'b0;
                m_top = top_val;
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                if ($urandom_range(9) < 7) begin
                    queue_deck_session();
                end else begin
                    burst = $urandom_range(24, 8);
                    for (int unsigned k = 0; k < burst; k++) begin
                        r = $urandom_range(9);
                        if (r < 6)
                            push_item(OP_SAMPLE, 4'($urandom_range(15)), 8'($urandom_range(255)));
                        else if (r == 6)
                            push_item(OP_POWER_UP, 4'($urandom_range(15)),
                                      8'($urandom_range(255)));
                        else if (r == 7)
                            push_item(OP_POWER_DOWN, 4'($urandom_range(15)),
                                      8'($urandom_range(255)));
                        else
                            push_item(OP_SET_MODE, 4'($urandom_range(15)), pick_mode());
                    end
                end
                // hold new beats until every expected result is back
                while (deck_item_q.size() > 0 || in_valid || deck_response_q.size() > 0)
                    @(negedge clk);
            end
        end

        repeat (20) @(negedge clk);
        if (fail_count == 0 && deck_response_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
